/* rtl/core/vca_pkg.sv */
// ----------------------------------------------------------------------------
// vca_pkg
// Shared types and constants for the Vigenere column analysis block.
// ----------------------------------------------------------------------------
package vca_pkg;

    localparam int ALPHABET_SIZE = 32;
    localparam int MAX_PERIOD    = 32;
    localparam int COUNT_BITS    = 16;
    localparam int LETTER_BITS   = $clog2(ALPHABET_SIZE);
    localparam int COL_BITS      = $clog2(MAX_PERIOD);
    localparam int ADDR_BITS     = COL_BITS + LETTER_BITS;
    localparam int MEM_DEPTH     = MAX_PERIOD * ALPHABET_SIZE;
    localparam int SUM_BITS      = 2 * COUNT_BITS + LETTER_BITS;
    localparam int DEN_BITS      = 2 * COUNT_BITS;
    localparam int Q_BITS        = 16;
    localparam int COIN_BITS     = Q_BITS + 1;
    localparam int PERIOD_BITS   = 6;
    localparam int CFG_IDX_BITS  = 1;
    localparam int CFG_DATA_BITS = 6;

    localparam logic [CFG_IDX_BITS-1:0] CFG_PERIOD = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_COMMON = 1'b1;

    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

    typedef enum logic [2:0] {
        ST_CLEAR,   // sweep the histogram memory to zero
        ST_RUN,     // accept letters
        ST_SCAN,    // walk the letters of one column
        ST_DIV,     // Q0.16 ratio, one bit a cycle
        ST_OUT,     // hold the result until transferred
        ST_NEXT     // advance to the next column or finish
    } vca_state_t;

    typedef struct packed {
        logic clear_mem;
        logic accept;
        logic scan_start;
        logic scan_step;
        logic div_start;
        logic div_step;
        logic out_load;
        logic next_col;
    } vca_cmd_t;

    typedef struct packed {
        logic clear_done;
        logic scan_done;
        logic div_done;
        logic last_col;
    } vca_status_t;

endpackage

/* rtl/core/vca_if.sv */
// ----------------------------------------------------------------------------
// vca_if
// Valid/ready channel interfaces for letters and results.
// ----------------------------------------------------------------------------
interface vca_letter_if;
    logic       valid;
    logic       ready;
    logic [4:0] letter;
    logic       last;
    modport source (output valid, output letter, output last, input ready);
    modport sink   (input valid, input letter, input last, output ready);
endinterface

interface vca_result_if;
    logic        valid;
    logic        ready;
    logic [4:0]  column;
    logic [16:0] coincidence;
    logic [15:0] column_length;
    logic [4:0]  top_letter;
    logic [4:0]  key_letter;
    logic        final_res;
    modport source (output valid, output column, output coincidence, output column_length,
                    output top_letter, output key_letter, output final_res, input ready);
    modport sink   (input valid, input column, input coincidence, input column_length,
                    input top_letter, input key_letter, input final_res, output ready);
endinterface

/* rtl/core/vca_ctrl.sv */
// ----------------------------------------------------------------------------
// vca_ctrl
// Sequencer: clear sweep, letter intake, per-column scan, divide and emit.
// ----------------------------------------------------------------------------
module vca_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_last,
    output logic                  in_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    output vca_pkg::vca_cmd_t     cmd,
    input  vca_pkg::vca_status_t  status
);
    import vca_pkg::*;

    vca_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: if (status.clear_done) state_next = ST_RUN;
            ST_RUN:   if (in_valid && in_last) state_next = ST_SCAN;
            ST_SCAN:  if (status.scan_done) state_next = ST_DIV;
            ST_DIV:   if (status.div_done) state_next = ST_OUT;
            ST_OUT:   if (out_ready) state_next = ST_NEXT;
            ST_NEXT:  state_next = status.last_col ? ST_CLEAR : ST_SCAN;
            default:  state_next = ST_CLEAR;
        endcase
    end

    always_comb begin
        cmd        = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        unique case (state_reg)
            ST_CLEAR: cmd.clear_mem = 1'b1;
            ST_RUN:
            begin
                in_ready       = 1'b1;
                cmd.accept     = in_valid;
                cmd.scan_start = in_valid && in_last;
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                cmd.div_start = status.scan_done;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                cmd.out_load = status.div_done;
            end
            ST_OUT:   out_valid = 1'b1;
            ST_NEXT:
            begin
                cmd.next_col   = 1'b1;
                cmd.scan_start = !status.last_col;
            end
            default: ;
        endcase
    end

endmodule

/* rtl/core/vca_datapath.sv */
// ----------------------------------------------------------------------------
// vca_datapath
// Histogram memory with forwarding, column lengths, scan, serial divider.
// ----------------------------------------------------------------------------
module vca_datapath (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic [vca_pkg::PERIOD_BITS-1:0]      period,
    input  logic [vca_pkg::LETTER_BITS-1:0]      common_letter,
    input  logic [vca_pkg::LETTER_BITS-1:0]      in_letter,
    input  vca_pkg::vca_cmd_t                    cmd,
    output vca_pkg::vca_status_t                 status,
    output logic [vca_pkg::COL_BITS-1:0]         column,
    output logic [vca_pkg::COIN_BITS-1:0]        coincidence,
    output logic [vca_pkg::COUNT_BITS-1:0]       column_length,
    output logic [vca_pkg::LETTER_BITS-1:0]      top_letter,
    output logic [vca_pkg::LETTER_BITS-1:0]      key_letter,
    output logic                                 final_res
);
    import vca_pkg::*;

    // effective period
    logic [COL_BITS:0] per_eff;
    always_comb begin
        if (period == '0)
            per_eff = (COL_BITS+1)'(1);
        else if (period > PERIOD_BITS'(MAX_PERIOD))
            per_eff = (COL_BITS+1)'(MAX_PERIOD);
        else
            per_eff = period[COL_BITS:0];
    end

    // histogram memory, registered read
    logic [COUNT_BITS-1:0] mem [MEM_DEPTH];
    logic [COUNT_BITS-1:0] rd_data_reg;
    logic [ADDR_BITS-1:0]  rd_addr, wr_addr;
    logic [COUNT_BITS-1:0] wr_data;
    logic                  wr_en;

    // intake pipeline: stage 1 holds the address being read
    logic                  p1_valid_reg;
    logic [ADDR_BITS-1:0]  p1_addr_reg;
    logic                  fwd_valid_reg;    // last write, for back-to-back hits
    logic [ADDR_BITS-1:0]  fwd_addr_reg;
    logic [COUNT_BITS-1:0] fwd_data_reg;
    logic [COUNT_BITS-1:0] p1_old, p1_new;

    logic [COL_BITS-1:0]   cur_col_reg, cur_col_next, col_in;
    logic [COUNT_BITS-1:0] len_reg [MAX_PERIOD];
    logic [ADDR_BITS-1:0]  clr_reg;
    logic                  clr_done_reg;

    always_comb begin
        col_in = ({1'b0, cur_col_reg} < per_eff) ? cur_col_reg : '0;
        cur_col_next = ({1'b0, col_in} + 1'b1 >= per_eff) ? '0 : col_in + 1'b1;
    end

    // scan
    logic [COL_BITS-1:0]    scol_reg;
    logic [LETTER_BITS:0]   sidx_reg;     // letter index issued to memory
    logic                   sval_reg;     // read data valid for sidx_reg-1
    logic [LETTER_BITS-1:0] sdat_idx_reg;
    logic [SUM_BITS-1:0]    sum_reg;
    logic [COUNT_BITS-1:0]  best_reg;
    logic [LETTER_BITS-1:0] top_reg;
    logic [2*COUNT_BITS-1:0] prod;

    assign prod = (rd_data_reg == '0) ? '0
                : rd_data_reg * (rd_data_reg - 1'b1);

    always_comb begin
        rd_addr = '0;
        wr_en   = 1'b0;
        wr_addr = '0;
        wr_data = '0;
        p1_old  = (fwd_valid_reg && fwd_addr_reg == p1_addr_reg) ? fwd_data_reg
                                                                  : rd_data_reg;
        p1_new  = (p1_old == CNT_MAX) ? CNT_MAX : p1_old + 1'b1;
        if (cmd.clear_mem)
        begin
            wr_en   = 1'b1;
            wr_addr = clr_reg;
        end
        else if (p1_valid_reg)
        begin
            wr_en   = 1'b1;
            wr_addr = p1_addr_reg;
            wr_data = p1_new;
        end
        if (cmd.accept)
            rd_addr = {col_in, in_letter};
        else
            rd_addr = {scol_reg, sidx_reg[LETTER_BITS-1:0]};
    end

    // write-first: the final letter's update lands in the same cycle as the
    // first scan read
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_data_reg <= (wr_en && wr_addr == rd_addr) ? wr_data : mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            p1_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
            cur_col_reg   <= '0;
            clr_reg       <= '0;
            clr_done_reg  <= 1'b0;
            for (int i = 0; i < MAX_PERIOD; i++)
                len_reg[i] <= '0;
        end
        else
        begin
            p1_valid_reg  <= cmd.accept;
            fwd_valid_reg <= p1_valid_reg;
            if (cmd.clear_mem)
            begin
                clr_reg      <= clr_reg + 1'b1;
                clr_done_reg <= (clr_reg == ADDR_BITS'(MEM_DEPTH - 2));
                cur_col_reg  <= '0;
                for (int i = 0; i < MAX_PERIOD; i++)
                    len_reg[i] <= '0;
            end
            else
            begin
                clr_reg      <= '0;
                clr_done_reg <= 1'b0;
            end
            if (cmd.accept)
            begin
                cur_col_reg <= cur_col_next;
                if (len_reg[col_in] != CNT_MAX)
                    len_reg[col_in] <= len_reg[col_in] + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        fwd_addr_reg <= p1_addr_reg;
        fwd_data_reg <= p1_new;
        if (cmd.accept)
            p1_addr_reg <= {col_in, in_letter};
    end

    // scan over letters of one column; the memory read is registered
    always_ff @(posedge clk)
    begin
        if (cmd.scan_start)
        begin
            if (cmd.accept)
                scol_reg <= '0;
            sidx_reg <= '0;
            sval_reg <= 1'b0;
            sum_reg  <= '0;
            best_reg <= '0;
            top_reg  <= '0;
        end
        else if (cmd.scan_step)
        begin
            if (!sidx_reg[LETTER_BITS])
                sidx_reg <= sidx_reg + 1'b1;
            sval_reg     <= !sidx_reg[LETTER_BITS];
            sdat_idx_reg <= sidx_reg[LETTER_BITS-1:0];
            if (sval_reg)
            begin
                sum_reg <= sum_reg + SUM_BITS'(prod);
                if (rd_data_reg > best_reg)
                begin
                    best_reg <= rd_data_reg;
                    top_reg  <= sdat_idx_reg;
                end
            end
        end
        if (cmd.next_col)
            scol_reg <= scol_reg + 1'b1;
    end

    // ensure scan waits for the pipeline tail of the final letter index
    assign status.scan_done  = cmd.scan_step && sidx_reg[LETTER_BITS] && !sval_reg;
    assign status.clear_done = clr_done_reg;
    assign status.last_col   = ({1'b0, scol_reg} + 1'b1 >= per_eff);

    // restoring Q0.16 divider, one quotient bit a cycle
    logic [COUNT_BITS-1:0] len_c;
    logic [DEN_BITS-1:0]   den_reg;
    logic [SUM_BITS:0]     rem_reg;
    logic [Q_BITS-1:0]     q_reg;
    logic [4:0]            dcnt_reg;
    logic                  dsat_reg, dzero_reg;
    logic [SUM_BITS:0]     diff;

    assign len_c = len_reg[scol_reg];
    assign diff  = (SUM_BITS+1)'(den_reg) - rem_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            den_reg   <= len_c * (len_c - 1'b1);
            rem_reg   <= (SUM_BITS+1)'(sum_reg);
            q_reg     <= '0;
            dcnt_reg  <= '0;
            dsat_reg  <= 1'b0;
            dzero_reg <= (len_c < COUNT_BITS'(2));
        end
        else if (cmd.div_step)
        begin
            if (dcnt_reg == '0)
                dsat_reg <= (rem_reg >= (SUM_BITS+1)'(den_reg));
            else
            begin
                q_reg <= {q_reg[Q_BITS-2:0], (rem_reg >= diff)};
                if (rem_reg >= diff)
                    rem_reg <= rem_reg - diff;
                else
                    rem_reg <= {rem_reg[SUM_BITS-1:0], 1'b0};
            end
            dcnt_reg <= dcnt_reg + 1'b1;
        end
    end
    assign status.div_done = cmd.div_step && (dcnt_reg == 5'(Q_BITS));

    // result register, loaded with the final quotient bit folded in
    logic [Q_BITS-1:0] q_fin;
    assign q_fin = {q_reg[Q_BITS-2:0], (rem_reg >= diff)};

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            column        <= scol_reg;
            column_length <= len_c;
            top_letter    <= top_reg;
            key_letter    <= top_reg - common_letter;
            final_res     <= status.last_col;
            if (dzero_reg)
                coincidence <= '0;
            else if (dsat_reg)
                coincidence <= COIN_BITS'(1 << Q_BITS);
            else
                coincidence <= {1'b0, q_fin};
        end
    end

endmodule

/* rtl/core/vigenere_column_analysis.sv */
// ----------------------------------------------------------------------------
// vigenere_column_analysis
// Per-column letter histograms and index of coincidence for key recovery.
// ----------------------------------------------------------------------------
// Usage:
//   letters: valid/ready channel of alphabet indices; one transfer a cycle
//     while letters stream in (histogram read-modify-write with forwarding).
//   results: on the letter marked last, one result per column 0..period-1
//     (0 taken as 1, at most 32) in column order; final_res marks the last.
//   Each column runs a histogram scan (one memory read a cycle over 32
//     letters), then a serial divide, then the result transfer and a step
//     to the next column.
//   Letters are not taken during the emit phase.
//   After reset and after each emit, a clearing pass sweeps the 1024-entry
//   histogram memory, during which no letter is accepted; configuration
//   writes are taken at any time.
//   A stalled receiver simply holds the result and the block waits.
//   Config: cfg_we, cfg_index (0 period, 1 common_letter), cfg_data.
// ----------------------------------------------------------------------------
module vigenere_column_analysis (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [vca_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [vca_pkg::CFG_DATA_BITS-1:0] cfg_data,
    vca_letter_if.sink                        letters,
    vca_result_if.source                      results
);
    import vca_pkg::*;

    logic [PERIOD_BITS-1:0] period_reg;
    logic [LETTER_BITS-1:0] common_reg;
    vca_cmd_t    cmd;
    vca_status_t status;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            period_reg <= PERIOD_BITS'(14);
            common_reg <= LETTER_BITS'(14);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_PERIOD: period_reg <= cfg_data[PERIOD_BITS-1:0];
                CFG_COMMON: common_reg <= cfg_data[LETTER_BITS-1:0];
                default: ;
            endcase
        end
    end

    vca_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (letters.valid),
        .in_last   (letters.last),
        .in_ready  (letters.ready),
        .out_valid (results.valid),
        .out_ready (results.ready),
        .cmd       (cmd),
        .status    (status)
    );

    vca_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .period        (period_reg),
        .common_letter (common_reg),
        .in_letter     (letters.letter),
        .cmd           (cmd),
        .status        (status),
        .column        (results.column),
        .coincidence   (results.coincidence),
        .column_length (results.column_length),
        .top_letter    (results.top_letter),
        .key_letter    (results.key_letter),
        .final_res     (results.final_res)
    );

endmodule
